/* sv/wcp_pkg.sv */
// Shared types and constants for the WAV chunk header parser.
package wcp_pkg;

  localparam logic [31:0] TagFmt    = 32'h2074_6D66;
  localparam logic [31:0] TagData   = 32'h6174_6164;
  localparam logic [31:0] RiffMagic = 32'h4646_4952;
  localparam logic [31:0] WaveMagic = 32'h4556_4157;
  localparam logic [31:0] MinFile   = 32'd44;
  localparam logic [31:0] FmtMin    = 32'd16;
  localparam logic [3:0]  BitsIdx   = 4'd14;
  localparam logic [32:0] HdrLen    = 33'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_RIFF  = 3'd2,
    ST_BAD_WAVE  = 3'd3,
    ST_NOT_PCM   = 3'd4,
    ST_DATA_EARLY = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_MAGIC  = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] file_size;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  channels;
    logic [31:0] rate_hz;
    logic [7:0]  depth_bits;
    logic [31:0] pcm_offset;
    logic [31:0] pcm_length;
  } result_t;

endpackage

/* sv/wcp_in_stage.sv */
// Input register that holds one accepted byte beat for the parse logic.
module wcp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wcp_pkg::in_beat_t beat_i,
  input  logic              take_i,
  output logic              valid_o,
  output wcp_pkg::in_beat_t beat_o
);
  import wcp_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

/* sv/wcp_parser.sv */
// Parse state registers and the single-pass logic that consumes one file byte.
module wcp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  wcp_pkg::in_beat_t beat_i,
  output logic              emit_o,
  output wcp_pkg::result_t  result_o
);
  import wcp_pkg::*;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] pos;
    logic [31:0] total;
    logic [31:0] tag;
    logic [31:0] len;
    logic [32:0] left;
    logic        fmt_seen;
    logic [7:0]  fmt_lo;
    logic [7:0]  chans;
    logic [31:0] rate;
    logic [7:0]  bits;
    logic [3:0]  idx;
    logic        done;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase: PH_IDLE, pos: '0, total: '0, tag: '0, len: '0, left: '0,
    fmt_seen: 1'b0, fmt_lo: '0, chans: '0, rate: '0, bits: '0, idx: '0,
    done: 1'b1
  };

  parse_state_t state_q, cur, nxt;
  logic [32:0]  np;
  logic [32:0]  left_dec;
  logic [2:0]   hidx;
  logic [31:0]  tag_new, len_new;
  logic         hdr_fits, body_fmt, too_short, work, hit, emit;
  status_e      hit_st, res_st;
  logic [31:0]  off;
  logic [31:0]  res_len;
  logic [7:0]   b;

  always_comb begin
    cur = state_q;
    if (beat_i.first_byte) begin
      cur       = StateReset;
      cur.total = beat_i.file_size;
      cur.done  = 1'b0;
      cur.phase = PH_MAGIC;
    end
    b         = beat_i.data_byte;
    nxt       = cur;
    np        = {1'b0, cur.pos} + 33'd1;
    left_dec  = cur.left - 33'd1;
    hidx      = 3'(4'd8 - cur.left[3:0]);
    tag_new   = cur.tag;
    len_new   = cur.len;
    hdr_fits  = (np + HdrLen) <= {1'b0, cur.total};
    body_fmt  = (cur.tag == TagFmt) && (cur.len >= FmtMin);
    too_short = beat_i.first_byte && (beat_i.file_size < MinFile);
    work      = !too_short && !cur.done;
    hit       = too_short;
    hit_st    = too_short ? ST_TOO_SHORT : ST_NOT_FOUND;
    off       = '0;
    res_len   = '0;
    emit      = 1'b0;
    res_st    = ST_NOT_FOUND;

    if (work) begin
      unique case (cur.phase)
        PH_MAGIC: begin
          if (cur.pos[31:2] == 30'd0 && b != RiffMagic[{cur.pos[1:0], 3'b000} +: 8]) begin
            hit    = 1'b1;
            hit_st = ST_BAD_RIFF;
          end else if (cur.pos[31:2] == 30'd2 &&
                       b != WaveMagic[{cur.pos[1:0], 3'b000} +: 8]) begin
            hit    = 1'b1;
            hit_st = ST_BAD_WAVE;
          end else if (cur.pos == 32'd11) begin
            if (hdr_fits) begin
              nxt.phase = PH_HEADER;
              nxt.left  = HdrLen;
            end else begin
              hit    = 1'b1;
              hit_st = ST_NOT_FOUND;
            end
          end
        end
        PH_HEADER: begin
          if (!hidx[2]) begin
            tag_new[{hidx[1:0], 3'b000} +: 8] = b;
          end else begin
            len_new[{hidx[1:0], 3'b000} +: 8] = b;
          end
          nxt.tag  = tag_new;
          nxt.len  = len_new;
          nxt.left = left_dec;
          if (left_dec == 33'd0) begin
            if (np + {1'b0, len_new} > {1'b0, cur.total}) begin
              hit    = 1'b1;
              hit_st = ST_NOT_FOUND;
            end else if (tag_new == TagData) begin
              hit = 1'b1;
              if (!cur.fmt_seen) begin
                hit_st = ST_DATA_EARLY;
              end else begin
                hit_st = ST_OK;
                off    = np[31:0];
              end
            end else begin
              nxt.left  = {1'b0, len_new} + {32'd0, len_new[0]};
              nxt.phase = PH_BODY;
              nxt.idx   = '0;
              if (len_new == 32'd0) begin
                if (hdr_fits) begin
                  nxt.phase = PH_HEADER;
                  nxt.left  = HdrLen;
                end else begin
                  hit    = 1'b1;
                  hit_st = ST_NOT_FOUND;
                end
              end
            end
          end
        end
        PH_BODY: begin
          if (body_fmt) begin
            priority if (cur.idx == 4'd0) begin
              nxt.fmt_lo = b;
            end else if (cur.idx == 4'd1) begin
              if ({b, cur.fmt_lo} != 16'd1) begin
                hit    = 1'b1;
                hit_st = ST_NOT_PCM;
              end
            end else if (cur.idx == 4'd2) begin
              nxt.chans = b;
            end else if (cur.idx[3:2] == 2'b01) begin
              nxt.rate[{cur.idx[1:0], 3'b000} +: 8] = b;
            end else if (cur.idx == BitsIdx) begin
              nxt.bits     = b;
              nxt.fmt_seen = 1'b1;
            end else begin
              nxt.idx = cur.idx;
            end
          end
          if (cur.idx != 4'hF) begin
            nxt.idx = cur.idx + 4'd1;
          end
          if (!hit) begin
            nxt.left = left_dec;
            if (left_dec == 33'd0) begin
              if (hdr_fits) begin
                nxt.phase = PH_HEADER;
                nxt.left  = HdrLen;
              end else begin
                hit    = 1'b1;
                hit_st = ST_NOT_FOUND;
              end
            end
          end
        end
        default: begin
          hit    = 1'b1;
          hit_st = ST_NOT_FOUND;
        end
      endcase
    end

    if (hit) begin
      emit    = 1'b1;
      res_st  = hit_st;
      res_len = nxt.len;
    end else if (work) begin
      nxt.pos = np[31:0];
      if (np >= {1'b0, cur.total}) begin
        emit   = 1'b1;
        res_st = ST_NOT_FOUND;
        off    = '0;
      end
    end

    if (emit) begin
      nxt.phase = PH_IDLE;
      nxt.done  = 1'b1;
    end
    if (!work && !too_short) begin
      nxt = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (step_i) begin
      state_q <= nxt;
    end
  end

  assign emit_o              = emit;
  assign result_o.status     = res_st;
  assign result_o.channels   = nxt.chans;
  assign result_o.rate_hz    = nxt.rate;
  assign result_o.depth_bits = nxt.bits;
  assign result_o.pcm_offset = (res_st == ST_OK) ? off : 32'd0;
  assign result_o.pcm_length = (res_st == ST_OK) ? res_len : 32'd0;

endmodule

/* sv/wcp_out_stage.sv */
// Result register that holds one parse outcome until the consumer takes it.
module wcp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wcp_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wcp_pkg::result_t result_o
);
  import wcp_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* sv/wav_chunk_header_parser_unit.sv */
// Top level of the RIFF/WAVE PCM header parser.
// The block takes a WAV file one byte per beat, the first byte flagged and carrying the
// file size, and returns one result per file: a status and the PCM format and data chunk
// position. It accepts one byte every clock cycle; a byte passes through an input register,
// one pass of parse logic and a result register, and the parse step loads the result that a
// byte in the input register decides into the result register. Input acceptance stalls only
// while a result waits in the full result register and the parse step that follows would need
// that register.
module wav_chunk_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [31:0] file_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  channels_o,
  output logic [31:0] rate_hz_o,
  output logic [7:0]  depth_bits_o,
  output logic [31:0] pcm_offset_o,
  output logic [31:0] pcm_length_o
);
  import wcp_pkg::*;

  in_beat_t in_beat, stage_beat;
  logic     stage_valid, out_free, step, emit;
  result_t  step_res, out_res;

  assign in_beat.data_byte  = data_byte_i;
  assign in_beat.first_byte = first_byte_i;
  assign in_beat.file_size  = file_size_i;

  assign step = stage_valid && (out_free || !emit);

  wcp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .beat_i     (in_beat),
    .take_i     (step),
    .valid_o    (stage_valid),
    .beat_o     (stage_beat)
  );

  wcp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .beat_i   (stage_beat),
    .emit_o   (emit),
    .result_o (step_res)
  );

  wcp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign status_o     = out_res.status;
  assign channels_o   = out_res.channels;
  assign rate_hz_o    = out_res.rate_hz;
  assign depth_bits_o = out_res.depth_bits;
  assign pcm_offset_o = out_res.pcm_offset;
  assign pcm_length_o = out_res.pcm_length;

  a_fail_no_pcm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (pcm_offset_o == 32'd0) && (pcm_length_o == 32'd0))
    else $error("Failed result carries a data chunk position.");

  a_short_no_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TOO_SHORT) |->
      (channels_o == 8'd0) && (rate_hz_o == 32'd0) && (depth_bits_o == 8'd0))
    else $error("Too-short result carries format fields.");

  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> (pcm_offset_o >= 32'd20))
    else $error("Data chunk body lies inside the RIFF header.");

endmodule
